[rtl/core/jtgc_pkg.sv]
`timescale 1ns / 1ps

package jtgc_pkg;

    localparam int POS_W    = 32;
    localparam int KIND_W   = 4;
    localparam int STATUS_W = 4;
    localparam int CKIND_W  = 2;
    localparam int NEST_W   = 6;

    // Token kinds. Codes above KIND_END can arrive and are treated as non-values.
    localparam logic [KIND_W-1:0] KIND_NULL        = 4'd0;
    localparam logic [KIND_W-1:0] KIND_TRUE        = 4'd1;
    localparam logic [KIND_W-1:0] KIND_FALSE       = 4'd2;
    localparam logic [KIND_W-1:0] KIND_IDENT       = 4'd3;
    localparam logic [KIND_W-1:0] KIND_STRING      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_NUMBER      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_OPEN_BRACE  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CLOSE_BRACE = 4'd7;
    localparam logic [KIND_W-1:0] KIND_OPEN_BRACK  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_CLOSE_BRACK = 4'd9;
    localparam logic [KIND_W-1:0] KIND_COLON       = 4'd10;
    localparam logic [KIND_W-1:0] KIND_COMMA       = 4'd11;
    localparam logic [KIND_W-1:0] KIND_END         = 4'd12;

    localparam logic [CKIND_W-1:0] CKIND_NONE   = 2'd0;
    localparam logic [CKIND_W-1:0] CKIND_ARRAY  = 2'd1;
    localparam logic [CKIND_W-1:0] CKIND_OBJECT = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 4'd0,
        ST_ACCEPTED      = 4'd1,
        ST_EMPTY         = 4'd2,
        ST_BAD_IDENT     = 4'd3,
        ST_BAD_PUNCT     = 4'd4,
        ST_INVALID_VALUE = 4'd5,
        ST_EXPECT_COMMA  = 4'd6,
        ST_BAD_NAME      = 4'd7,
        ST_EXPECT_COLON  = 4'd8,
        ST_EARLY_CLOSE   = 4'd9,
        ST_UNTERMINATED  = 4'd10,
        ST_EXTRA         = 4'd11,
        ST_TOO_DEEP      = 4'd12,
        ST_IGNORED       = 4'd13
    } status_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_INSIDE = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        PEND_VALUE = 2'd0,
        PEND_NAME  = 2'd1,
        PEND_COLON = 2'd2,
        PEND_COMMA = 2'd3
    } pend_t;

    typedef struct packed {
        logic             is_obj;
        pend_t            pend;
        logic [POS_W-1:0] start;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_SET   = 3'd1,
        ACT_PUSH  = 3'd2,
        ACT_POP   = 3'd3,
        ACT_CLEAR = 3'd4
    } stack_act_t;

    typedef struct packed {
        stack_act_t act;
        pend_t      pend;   // new pending state of the current top
        frame_t     frame;  // frame opened by a push
    } stack_op_t;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
    } stack_flags_t;

    typedef struct packed {
        status_t   status;
        phase_t    phase;
        stack_op_t op;
    } step_t;

endpackage

[rtl/core/jtgc_ram.sv]
`timescale 1ns / 1ps

module jtgc_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/jtgc_stack.sv]
`timescale 1ns / 1ps

module jtgc_stack import jtgc_pkg::*; #(
    parameter int DEPTH = 32,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  stack_op_t    op,
    output frame_t       top,
    output frame_t       top_next,
    output logic [CW-1:0] count_next,
    output stack_flags_t flags
);

    // The top frame lives in flops; the frames beneath it live in the RAM.
    // The RAM is always read at the slot just below the next top, so a pop
    // finds its new top already registered at the RAM output.
    logic [CW-1:0] count_reg;
    frame_t        top_reg;
    logic          bypass_reg;
    frame_t        bypass_data_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    frame_t        wdata;
    logic [FRAME_W-1:0] rdata;
    frame_t        below;

    assign below = bypass_reg ? bypass_data_reg : frame_t'(rdata);

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        we         = 1'b0;
        wdata      = '{is_obj: top_reg.is_obj, pend: op.pend, start: top_reg.start};
        if (en) begin
            unique case (op.act)
                ACT_SET: begin
                    top_next.pend = op.pend;
                end
                ACT_PUSH: begin
                    we         = (count_reg != '0);
                    top_next   = op.frame;
                    count_next = count_reg + CW'(1);
                end
                ACT_POP: begin
                    top_next   = below;
                    count_next = count_reg - CW'(1);
                end
                ACT_CLEAR: begin
                    count_next = '0;
                end
                ACT_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign waddr = AW'(count_reg - CW'(1));
    assign raddr = AW'(count_next - CW'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            bypass_reg <= we && (waddr == raddr);
        end
        top_reg         <= top_next;
        bypass_data_reg <= wdata;
    end

    jtgc_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign top         = top_reg;
    assign flags.empty = (count_reg == '0);
    assign flags.one   = (count_reg == CW'(1));
    assign flags.full  = (count_reg >= CW'(DEPTH));

endmodule

[rtl/core/jtgc_step.sv]
`timescale 1ns / 1ps

module jtgc_step import jtgc_pkg::*; (
    input  logic [KIND_W-1:0] kind,
    input  logic [POS_W-1:0]  pos,
    input  phase_t            phase,
    input  frame_t            top,
    input  stack_flags_t      flags,
    output step_t             res
);

    logic   is_scalar;
    logic   is_open;
    logic   is_name;
    frame_t new_frame;
    step_t  base;
    step_t  tv;

    assign is_scalar = (kind == KIND_NULL) || (kind == KIND_TRUE) || (kind == KIND_FALSE) ||
                       (kind == KIND_STRING) || (kind == KIND_NUMBER);
    assign is_open   = (kind == KIND_OPEN_BRACE) || (kind == KIND_OPEN_BRACK);
    assign is_name   = (kind <= KIND_STRING);

    assign new_frame.is_obj = (kind == KIND_OPEN_BRACE);
    assign new_frame.pend   = (kind == KIND_OPEN_BRACE) ? PEND_NAME : PEND_VALUE;
    assign new_frame.start  = pos;

    always_comb begin
        base.status   = ST_OK;
        base.phase    = phase;
        base.op.act   = ACT_NONE;
        base.op.pend  = top.pend;
        base.op.frame = new_frame;
    end

    // A value where a container expects one.
    always_comb begin
        tv = base;
        if (is_scalar) begin
            tv.op.act  = ACT_SET;
            tv.op.pend = PEND_COMMA;
        end else if (is_open) begin
            if (flags.full) begin
                tv.status = ST_TOO_DEEP;
            end else begin
                tv.op.act  = ACT_PUSH;
                tv.op.pend = PEND_COMMA;
                tv.phase   = PH_INSIDE;
            end
        end else begin
            tv.status = ST_INVALID_VALUE;
        end
    end

    always_comb begin
        res = base;
        if (kind == KIND_END) begin
            unique case (phase)
                PH_FIRST:  res.status = ST_EMPTY;
                PH_INSIDE: res.status = ST_UNTERMINATED;
                PH_DONE:   res.status = ST_ACCEPTED;
                PH_ERROR:  res.status = ST_IGNORED;
                default:   res.status = ST_IGNORED;
            endcase
            res.phase  = PH_FIRST;
            res.op.act = ACT_CLEAR;
        end else begin
            unique case (phase)
                PH_ERROR: res.status = ST_IGNORED;
                PH_DONE:  res.status = ST_EXTRA;
                PH_FIRST: begin
                    priority if (is_scalar) begin
                        res.phase = PH_DONE;
                    end else if (kind == KIND_IDENT) begin
                        res.status = ST_BAD_IDENT;
                    end else if (is_open) begin
                        if (flags.full) begin
                            res.status = ST_TOO_DEEP;
                        end else begin
                            res.op.act = ACT_PUSH;
                            res.phase  = PH_INSIDE;
                        end
                    end else if ((kind == KIND_CLOSE_BRACE) || (kind == KIND_CLOSE_BRACK) ||
                                 (kind == KIND_COLON) || (kind == KIND_COMMA)) begin
                        res.status = ST_BAD_PUNCT;
                    end else begin
                        res.status = ST_INVALID_VALUE;
                    end
                end
                PH_INSIDE: begin
                    if (flags.empty) begin
                        res.status = ST_INVALID_VALUE;
                    end else if (!top.is_obj) begin
                        priority if (kind == KIND_CLOSE_BRACK) begin
                            res.op.act = ACT_POP;
                            res.phase  = flags.one ? PH_DONE : PH_INSIDE;
                        end else if (top.pend == PEND_COMMA) begin
                            if (kind == KIND_COMMA) begin
                                res.op.act  = ACT_SET;
                                res.op.pend = PEND_VALUE;
                            end else begin
                                res.status = ST_EXPECT_COMMA;
                            end
                        end else begin
                            res = tv;
                        end
                    end else if (kind == KIND_CLOSE_BRACE) begin
                        if ((top.pend == PEND_NAME) || (top.pend == PEND_COMMA)) begin
                            res.op.act = ACT_POP;
                            res.phase  = flags.one ? PH_DONE : PH_INSIDE;
                        end else begin
                            res.status = ST_EARLY_CLOSE;
                        end
                    end else begin
                        unique case (top.pend)
                            PEND_NAME: begin
                                if (is_name) begin
                                    res.op.act  = ACT_SET;
                                    res.op.pend = PEND_COLON;
                                end else begin
                                    res.status = ST_BAD_NAME;
                                end
                            end
                            PEND_COLON: begin
                                if (kind == KIND_COLON) begin
                                    res.op.act  = ACT_SET;
                                    res.op.pend = PEND_VALUE;
                                end else begin
                                    res.status = ST_EXPECT_COLON;
                                end
                            end
                            PEND_VALUE: res = tv;
                            PEND_COMMA: begin
                                if (kind == KIND_COMMA) begin
                                    res.op.act  = ACT_SET;
                                    res.op.pend = PEND_NAME;
                                end else begin
                                    res.status = ST_EXPECT_COMMA;
                                end
                            end
                            default: res.status = ST_EXPECT_COMMA;
                        endcase
                    end
                end
                default: res.status = ST_IGNORED;
            endcase

            // Any real error freezes the stack and makes the error sticky.
            if ((res.status != ST_OK) && (res.status != ST_ACCEPTED) &&
                (res.status != ST_EMPTY) && (res.status != ST_IGNORED)) begin
                res.phase  = PH_ERROR;
                res.op.act = ACT_NONE;
            end
        end
    end

endmodule

[rtl/core/json5_token_grammar_checker_unit.sv]
`timescale 1ns / 1ps

// JSON5 token grammar checker. Each beat on the slave side carries one token
// (kind in tuser, start offset in tdata) and yields exactly one result beat
// with a status code, the token offset, and the innermost open container
// with the nesting depth after the token. The unit takes one token per clock
// while the result side is not stalled. A token lands in the input register,
// and its result is loaded into the result register when that register is
// free or being drained. That rate is possible because the top of the stack
// is kept in flops while the frames below it sit in a RAM that is always
// prefetched at the next slot down. Errors are sticky until the end token,
// which also restarts the unit. STACK_DEPTH bounds the open containers;
// nesting_depth reports the count modulo 64.
module json5_token_grammar_checker_unit import jtgc_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] token_position
    input  logic [3:0]  s_axis_tuser,   // [3:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [3:0] status, [35:4] error_position,
                                        // [67:36] container_position,
                                        // [69:68] container_kind,
                                        // [75:70] nesting_depth, [79:76] zero
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic               in_valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               advance;

    phase_t             phase_reg;
    phase_t             phase_next;

    step_t              step;
    frame_t             top;
    frame_t             top_next;
    logic [CW-1:0]      count_next;
    stack_flags_t       flags;

    logic               m_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [POS_W-1:0]   err_pos_reg;
    logic [POS_W-1:0]   cpos_reg;
    logic [POS_W-1:0]   cpos_next;
    logic [CKIND_W-1:0] ckind_reg;
    logic [CKIND_W-1:0] ckind_next;
    logic [NEST_W-1:0]  nest_reg;

    // A token is processed when the result register is free or being drained.
    assign advance       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            kind_reg <= s_axis_tuser;
            pos_reg  <= s_axis_tdata;
        end
    end

    jtgc_step u_step (
        .kind (kind_reg),
        .pos  (pos_reg),
        .phase(phase_reg),
        .top  (top),
        .flags(flags),
        .res  (step)
    );

    jtgc_stack #(
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .op        (step.op),
        .top       (top),
        .top_next  (top_next),
        .count_next(count_next),
        .flags     (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            phase_next = step.phase;
        end
    end

    always_comb begin
        if (count_next != '0) begin
            cpos_next  = top_next.start;
            ckind_next = top_next.is_obj ? CKIND_OBJECT : CKIND_ARRAY;
        end else begin
            cpos_next  = '0;
            ckind_next = CKIND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            status_reg  <= step.status;
            err_pos_reg <= pos_reg;
            cpos_reg    <= cpos_next;
            ckind_reg   <= ckind_next;
            nest_reg    <= NEST_W'(count_next);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, nest_reg, ckind_reg, cpos_reg, err_pos_reg, status_reg};

endmodule

[rtl/core/jtgc_checker.sv]
`timescale 1ns / 1ps

module jtgc_checker import jtgc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    logic [3:0] r_status;
    logic [1:0] r_ckind;
    logic [5:0] r_nest;

    assign r_status = m_axis_tdata[3:0];
    assign r_ckind  = m_axis_tdata[69:68];
    assign r_nest   = m_axis_tdata[75:70];

    // A stalled result beat must hold its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Right after reset nothing is held, so the input side is open.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("unit not idle right after reset");

    // No open container means a zero depth, and zero offset.
    a_none_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (r_ckind == CKIND_NONE) |-> (r_nest == '0) &&
        (m_axis_tdata[67:36] == '0))
        else $error("container reported as none with nonzero depth or offset");

    // Each accepted, empty or unterminated end-of-stream status comes with an emptied stack.
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && ((r_status == ST_ACCEPTED) || (r_status == ST_EMPTY) ||
        (r_status == ST_UNTERMINATED)) |-> (r_ckind == CKIND_NONE))
        else $error("stack not cleared on end of stream");

    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (r_status <= ST_IGNORED) && (r_ckind != 2'd3) &&
        (m_axis_tdata[79:76] == 4'd0))
        else $error("result carries an undefined code");

endmodule

bind json5_token_grammar_checker_unit jtgc_checker u_jtgc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
